/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each use expects clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define MBD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset
`define MBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/mbd_pkg.sv */
// ----------------------------------------------------------------------------
// mbd_pkg
// Types and constants shared by the multi-button debouncer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbd_pkg;

  localparam int NumButtons    = 3;
  localparam int TimeBits      = 48;
  localparam int IdxBits       = 2;
  localparam int DebounceBits  = 16;
  localparam logic [DebounceBits-1:0] DebounceReset = 16'd20;

  // Command codes
  localparam logic CmdSample = 1'b0;
  localparam logic CmdReinit = 1'b1;

  // Input word
  typedef struct packed {
    logic                  cmd;
    logic [TimeBits-1:0]   sample_time_ms;
    logic [NumButtons-1:0] button_levels;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [IdxBits-1:0]  button_index;
    logic                is_press;
    logic [TimeBits-1:0] event_time_ms;
    logic                last_event;
  } out_word_t;

  // Events produced by one sample, handed from core to event queue
  typedef struct packed {
    logic [NumButtons-1:0] mask;
    logic [NumButtons-1:0] levels;
    logic [TimeBits-1:0]   stamp;
  } evt_t;

endpackage

/* hdl/mbd_in_stage.sv */
// ----------------------------------------------------------------------------
// mbd_in_stage
// Input register: holds one sample word until the core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mbd_pkg::in_word_t in_word_i,
  input  logic              take_i,
  output logic              held_valid_o,
  output mbd_pkg::in_word_t held_word_o
);

  logic              valid_q, valid_d;
  mbd_pkg::in_word_t word_q;
  logic              accept;

  // Stall only while the held word is not leaving this cycle
  assign in_stall_o = valid_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= in_word_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_word_o  = word_q;

endmodule

/* hdl/mbd_core.sv */
// ----------------------------------------------------------------------------
// mbd_core
// Per-button debounce state and the single-pass update for one sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbd_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mbd_pkg::DebounceBits-1:0]     cfg_data_i,
  input  logic                                 held_valid_i,
  input  mbd_pkg::in_word_t                    held_word_i,
  input  logic                                 buf_free_i,
  output logic                                 take_o,
  output mbd_pkg::evt_t                        evt_o
);

  logic [mbd_pkg::DebounceBits-1:0] debounce_q;
  logic [mbd_pkg::TimeBits-1:0]     since_q [mbd_pkg::NumButtons];
  logic [mbd_pkg::TimeBits-1:0]     since_d [mbd_pkg::NumButtons];
  logic [mbd_pkg::NumButtons-1:0]   cand_q, cand_d;
  logic [mbd_pkg::NumButtons-1:0]   stable_q, stable_d;
  logic [mbd_pkg::TimeBits-1:0]     last_q, last_d;
  logic                             init_q, init_d;

  logic [mbd_pkg::TimeBits-1:0]     held [mbd_pkg::NumButtons];
  logic [mbd_pkg::TimeBits-1:0]     now;
  logic [mbd_pkg::TimeBits-1:0]     deb_wide;
  logic [mbd_pkg::NumButtons-1:0]   lv;
  logic [mbd_pkg::NumButtons-1:0]   mask;

  assign now      = held_word_i.sample_time_ms;
  assign lv       = held_word_i.button_levels;
  assign deb_wide = mbd_pkg::TimeBits'(debounce_q);
  assign take_o   = held_valid_i & buf_free_i;

  // Time each candidate has held, modulo the time width
  always_comb begin
    for (int i = 0; i < mbd_pkg::NumButtons; i++) begin
      held[i] = now - since_q[i];
    end
  end

  // State update for the sample being taken
  always_comb begin
    since_d  = since_q;
    cand_d   = cand_q;
    stable_d = stable_q;
    last_d   = last_q;
    init_d   = init_q;
    mask     = '0;
    if (take_o) begin
      if (held_word_i.cmd == mbd_pkg::CmdReinit || !init_q) begin
        // first sample or reinit: load everything, no events
        for (int i = 0; i < mbd_pkg::NumButtons; i++) begin
          since_d[i] = now;
        end
        cand_d   = lv;
        stable_d = lv;
        last_d   = now;
        init_d   = 1'b1;
      end else if (now >= last_q) begin
        last_d = now;
        for (int i = 0; i < mbd_pkg::NumButtons; i++) begin
          if (lv[i] != cand_q[i]) begin
            // level change restarts the candidate
            cand_d[i]  = lv[i];
            since_d[i] = now;
          end else if (lv[i] != stable_q[i] && held[i] >= deb_wide) begin
            stable_d[i] = lv[i];
            mask[i]     = 1'b1;
          end
        end
      end
      // time running backward: sample dropped
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= mbd_pkg::DebounceReset;
      cand_q     <= '0;
      stable_q   <= '0;
      last_q     <= '0;
      init_q     <= 1'b0;
      for (int i = 0; i < mbd_pkg::NumButtons; i++) begin
        since_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        debounce_q <= cfg_data_i;
      end
      cand_q   <= cand_d;
      stable_q <= stable_d;
      last_q   <= last_d;
      init_q   <= init_d;
      for (int i = 0; i < mbd_pkg::NumButtons; i++) begin
        since_q[i] <= since_d[i];
      end
    end
  end

  assign evt_o.mask   = mask;
  assign evt_o.levels = lv;
  assign evt_o.stamp  = now;

endmodule

/* hdl/mbd_evq.sv */
// ----------------------------------------------------------------------------
// mbd_evq
// Result register: holds one sample's events and sends them out one word
// per cycle unless stalled, in ascending button order, flagging the last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbd_evq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  mbd_pkg::evt_t      evt_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mbd_pkg::out_word_t out_word_o
);

  logic [mbd_pkg::NumButtons-1:0] mask_q, mask_d;
  logic [mbd_pkg::NumButtons-1:0] levels_q;
  logic [mbd_pkg::TimeBits-1:0]   stamp_q;
  logic [mbd_pkg::NumButtons-1:0] lowest;
  logic [mbd_pkg::NumButtons-1:0] rest;
  logic [mbd_pkg::IdxBits-1:0]    idx;
  logic                           pop;

  // Pick the lowest pending button
  assign lowest = mask_q & (~mask_q + 1'b1);
  assign rest   = mask_q & ~lowest;

  always_comb begin
    idx = '0;
    for (int i = 0; i < mbd_pkg::NumButtons; i++) begin
      if (lowest[i]) begin
        idx = mbd_pkg::IdxBits'(i);
      end
    end
  end

  assign out_valid_o = |mask_q;
  assign pop         = out_valid_o & ~out_stall_i;
  // Free when empty or the final word leaves now
  assign free_o      = ~out_valid_o | (pop & (rest == '0));

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = evt_i.mask;
    end else if (pop) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      levels_q <= evt_i.levels;
      stamp_q  <= evt_i.stamp;
    end
  end

  assign out_word_o.button_index  = idx;
  assign out_word_o.is_press      = |(lowest & levels_q);
  assign out_word_o.event_time_ms = stamp_q;
  assign out_word_o.last_event    = (rest == '0);

endmodule

/* hdl/multi_button_time_debouncer_top.sv */
// ----------------------------------------------------------------------------
// multi_button_time_debouncer_top
// Timestamped debouncer for three buttons with press/release events.
//
//   channel | direction | handshake           | word
//   --------+-----------+---------------------+-------------------
//   in      | input     | in_valid_i/stall_o  | mbd_pkg::in_word_t
//   out     | output    | out_valid_o/stall_i | mbd_pkg::out_word_t
//   cfg     | input     | cfg_valid_i/ready_o | debounce_ms, 16 bit
//
// A sample enters the input register and is processed combinationally
// by the core once the result register is free; its events are then
// registered there. A sample with k events holds the result register
// until all k have left; one with no events never enters it, so the
// input takes a word every cycle while the result register is free.
// Reset clears all button state, marks the block uninitialized and sets
// debounce_ms to 20. An output stall holds the result register and, once
// the input register is also full, stalls the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_button_time_debouncer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  mbd_pkg::in_word_t                 in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output mbd_pkg::out_word_t                out_word_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mbd_pkg::DebounceBits-1:0]  cfg_data_i
);

  logic              take;
  logic              held_valid;
  mbd_pkg::in_word_t held_word;
  logic              buf_free;
  mbd_pkg::evt_t     evt;
  logic              load;

  // Config register is always writable
  assign cfg_ready_o = 1'b1;

  mbd_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .take_i      (take),
    .held_valid_o(held_valid),
    .held_word_o (held_word)
  );

  mbd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .held_valid_i(held_valid),
    .held_word_i (held_word),
    .buf_free_i  (buf_free),
    .take_o      (take),
    .evt_o       (evt)
  );

  // Only samples that produce events occupy the result register
  assign load = take & (|evt.mask);

  mbd_evq u_evq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .evt_i      (evt),
    .free_o     (buf_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // A new sample is only taken when the pending events are done
  `MBD_ASSERT_IMPL(a_take_when_drained, take,
                   !out_valid_o || (out_word_o.last_event && !out_stall_i))
  // A non-final event delivered is followed by another event
  `MBD_ASSERT_NEXT(a_more_follow, out_valid_o && !out_stall_i && !out_word_o.last_event,
                   out_valid_o)
  // Event index stays within the button count
  `MBD_ASSERT_IMPL(a_index_range, out_valid_o,
                   32'(out_word_o.button_index) < mbd_pkg::NumButtons)

endmodule
